[rtl/ocm_pkg.sv]
// ----------------------------------------------------------------------------
// ocm_pkg
// Shared types and constants of the outer contour marker: beat layouts,
// pixel codes, register indexes and the item record passed to the window.
// ----------------------------------------------------------------------------
package ocm_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;

  localparam int unsigned ColW  = $clog2(MaxWidth);      // column index bits
  localparam int unsigned WCfgW = 11;                    // frame_width register
  localparam int unsigned HCfgW = 13;                    // frame_height register
  localparam int unsigned RowW  = 13;                    // row counter, holds overrun
  localparam int unsigned PendW = 11;                    // drains owed, up to width+1
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned PixW  = 2;
  localparam int unsigned LineW = 2 * PixW;              // upper and middle row

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'd1;

  // Operation codes.
  localparam logic OpPixel = 1'b0;
  localparam logic OpDrain = 1'b1;

  // Pixel codes.
  localparam logic [PixW-1:0] PixEmpty   = 2'd0;
  localparam logic [PixW-1:0] PixFilled  = 2'd1;
  localparam logic [PixW-1:0] PixContour = 2'd2;

  typedef struct packed {
    logic            operation;
    logic [PixW-1:0] pixel_in;
  } in_beat_t;

  typedef struct packed {
    logic [PixW-1:0] pixel_out;
    logic            frame_end;
  } out_beat_t;

  // One pushed item on its way from the position logic to the window.
  typedef struct packed {
    logic            valid;
    logic [ColW-1:0] addr;       // column, also the line store address
    logic [PixW-1:0] pix;        // pixel shifted in (empty for a drain)
    logic            col_zero;   // first column of a row
    logic            row_ge1;
    logic            row_ge2;
    logic [2:0]      col_ok;     // window column lies inside the marking band
    logic [2:0]      row_ok;     // window row lies inside the marking band
    logic            frame_end;
    logic            fwd;        // line data comes from the previous write
  } ocm_item_t;

endpackage

[rtl/ocm_ram.sv]
// ----------------------------------------------------------------------------
// ocm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. A read at the address being written returns old data.
// ----------------------------------------------------------------------------
module ocm_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ocm_ctrl.sv]
// ----------------------------------------------------------------------------
// ocm_ctrl
// Frame registers, raster position and drain bookkeeping. Decides at input
// acceptance whether a beat pushes the window, issues the line store read
// and holds the pushed item for the window stage.
// ----------------------------------------------------------------------------
module ocm_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ocm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [ocm_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ocm_pkg::in_beat_t                 in_data_i,
  input  logic                              take_i,      // window stage can move on
  output logic                              rd_en_o,
  output logic [ocm_pkg::ColW-1:0]          rd_addr_o,
  output ocm_pkg::ocm_item_t                item_o
);

  logic [ocm_pkg::WCfgW-1:0] frame_width_q;
  logic [ocm_pkg::HCfgW-1:0] frame_height_q;
  logic [ocm_pkg::ColW-1:0]  col_q, col_d;
  logic [ocm_pkg::RowW-1:0]  row_q, row_d;
  logic [ocm_pkg::PendW-1:0] pend_q, pend_d;
  ocm_pkg::ocm_item_t        item_q, item_d;

  logic [ocm_pkg::WCfgW-1:0] w_eff;
  logic [ocm_pkg::HCfgW-1:0] h_eff;
  logic [ocm_pkg::ColW:0]    col_inc;
  logic [ocm_pkg::RowW:0]    row_inc;
  logic                      row_end, last, is_pix, push, accept;
  logic [ocm_pkg::ColW+1:0]  col_sum;
  logic [ocm_pkg::RowW+1:0]  row_sum;

  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = ocm_pkg::WCfgW'(1);
    end else if (frame_width_q > ocm_pkg::WCfgW'(ocm_pkg::MaxWidth)) begin
      w_eff = ocm_pkg::WCfgW'(ocm_pkg::MaxWidth);
    end else begin
      w_eff = frame_width_q;
    end
    if (frame_height_q == '0) begin
      h_eff = ocm_pkg::HCfgW'(1);
    end else if (frame_height_q > ocm_pkg::HCfgW'(ocm_pkg::MaxHeight)) begin
      h_eff = ocm_pkg::HCfgW'(ocm_pkg::MaxHeight);
    end else begin
      h_eff = frame_height_q;
    end
  end

  assign in_ready_o = !item_q.valid || take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_pix     = (in_data_i.operation == ocm_pkg::OpPixel);
  assign push       = is_pix ? (pend_q == '0) : (pend_q != '0);

  assign col_inc = {1'b0, col_q} + 1'b1;
  assign row_inc = {1'b0, row_q} + 1'b1;
  assign row_end = ({1'b0, col_inc} >= {1'b0, w_eff});
  assign last    = (row_inc >= (ocm_pkg::RowW+1)'(h_eff)) && row_end;

  assign rd_en_o   = accept && push;
  assign rd_addr_o = col_q;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    if (accept && push) begin
      if (row_end) begin
        col_d = '0;
        row_d = row_inc[ocm_pkg::RowW-1:0];
      end else begin
        col_d = col_inc[ocm_pkg::ColW-1:0];
      end
      if (is_pix) begin
        if (last) begin
          pend_d = ocm_pkg::PendW'(w_eff) + 1'b1;
          col_d  = '0;
          row_d  = ocm_pkg::RowW'(h_eff);
        end
      end else begin
        pend_d = pend_q - 1'b1;
        if (pend_q == ocm_pkg::PendW'(1)) begin
          col_d = '0;
          row_d = '0;
        end
      end
    end
  end

  // Band tests for the window that this push produces: neighbor column
  // c-2+i must lie in [2, W-3] and neighbor row r-2+j in [2, H-3].
  always_comb begin
    item_d           = item_q;
    item_d.valid     = accept && push;
    item_d.addr      = col_q;
    item_d.pix       = is_pix ? in_data_i.pixel_in : ocm_pkg::PixEmpty;
    item_d.col_zero  = (col_q == '0);
    item_d.row_ge1   = (row_q != '0);
    item_d.row_ge2   = (row_q >= ocm_pkg::RowW'(2));
    item_d.frame_end = !is_pix && (pend_q == ocm_pkg::PendW'(1));
    item_d.fwd       = item_q.valid && take_i && (item_q.addr == col_q);
    for (int i = 0; i < 3; i++) begin
      col_sum = {2'b00, col_q} + (ocm_pkg::ColW+2)'(i);
      row_sum = {1'b0, row_q} + (ocm_pkg::RowW+1)'(i);
      item_d.col_ok[i] = (col_sum >= (ocm_pkg::ColW+2)'(4)) &&
                         ((col_sum + 1'b1) <= (ocm_pkg::ColW+2)'(w_eff));
      item_d.row_ok[i] = (row_sum >= (ocm_pkg::RowW+1)'(4)) &&
                         ((row_sum + 1'b1) <= (ocm_pkg::RowW+1)'(h_eff));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= ocm_pkg::WCfgW'(1024);
      frame_height_q <= ocm_pkg::HCfgW'(1024);
      col_q          <= '0;
      row_q          <= '0;
      pend_q         <= '0;
      item_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ocm_pkg::RegFrameWidth:  frame_width_q  <= cfg_data_i[ocm_pkg::WCfgW-1:0];
          ocm_pkg::RegFrameHeight: frame_height_q <= cfg_data_i[ocm_pkg::HCfgW-1:0];
          default: ;
        endcase
      end
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
      if (in_ready_o) begin
        item_q <= item_d;
      end
    end
  end

  assign item_o = item_q;

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= ocm_pkg::PendW'(ocm_pkg::MaxWidth + 1))
    else $error("drain count beyond the widest row plus one");

  a_drain_done_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(pend_q) != '0 && pend_q == '0) |-> (col_q == '0 && row_q == '0))
    else $error("position not returned home after the last drain");

  a_pixel_dropped_while_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_pix && pend_q != '0) |=> !item_q.valid)
    else $error("pixel beat pushed while drains are owed");

endmodule

[rtl/ocm_window.sv]
// ----------------------------------------------------------------------------
// ocm_window
// 3x3 window stage: merges the line store read with forwarding, writes the
// line store back, shifts the window, applies the contour rule and holds the
// result beat in the output register.
// ----------------------------------------------------------------------------
module ocm_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ocm_pkg::ocm_item_t            item_i,
  input  logic [ocm_pkg::LineW-1:0]     rd_data_i,
  output logic                          take_o,
  output logic                          wr_en_o,
  output logic [ocm_pkg::ColW-1:0]      wr_addr_o,
  output logic [ocm_pkg::LineW-1:0]     wr_data_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ocm_pkg::out_beat_t            out_data_o
);

  // Indexed [column][row], column 0 oldest, row 0 upper.
  logic [2:0][2:0][ocm_pkg::PixW-1:0] win_q, win_d;
  logic [ocm_pkg::LineW-1:0]          fwd_q, line;
  logic                               out_valid_q;
  ocm_pkg::out_beat_t                 out_q, res;
  logic [ocm_pkg::PixW-1:0]           centre;
  logic                               hit, emit, step;

  assign take_o = !out_valid_q || out_ready_i;
  assign step   = item_i.valid && take_o;
  assign line   = item_i.fwd ? fwd_q : rd_data_i;

  assign wr_en_o   = step;
  assign wr_addr_o = item_i.addr;
  assign wr_data_o = {line[ocm_pkg::PixW-1:0], item_i.pix};

  always_comb begin
    win_d[0]    = win_q[1];
    win_d[1]    = win_q[2];
    win_d[2][0] = line[ocm_pkg::LineW-1:ocm_pkg::PixW];
    win_d[2][1] = line[ocm_pkg::PixW-1:0];
    win_d[2][2] = item_i.pix;
    // The new center equals the old right-middle cell, which is also the
    // right-edge pixel released at the start of a row.
    centre = win_q[2][1];
    hit    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (!(i == 1 && j == 1) && win_d[i][j] == ocm_pkg::PixFilled &&
            item_i.col_ok[i] && item_i.row_ok[j]) begin
          hit = 1'b1;
        end
      end
    end
    emit            = item_i.col_zero ? item_i.row_ge2 : item_i.row_ge1;
    res.pixel_out   = (!item_i.col_zero && hit && centre == ocm_pkg::PixEmpty) ?
                      ocm_pkg::PixContour : centre;
    res.frame_end   = item_i.frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        win_q <= win_d;
      end
      if (step && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      fwd_q <= wr_data_o;
    end
    if (step && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(item_i.valid))
    else $error("result beat appeared without a pushed item");

  // An item that just arrived with forwarding set must follow a write.
  a_fwd_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.fwd && $past(take_o)) |-> $past(step))
    else $error("forwarded line data without a preceding write");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("result beat changed while waiting");

endmodule

[rtl/outer_contour_marker_3x3.sv]
// ----------------------------------------------------------------------------
// outer_contour_marker_3x3
// Marks the outer contour of filled areas in a raster stream of 2-bit
// pixels: an empty pixel becomes contour when a filled pixel at least two
// pixels inside every frame edge touches it, using a 3x3 window fed by
// two line buffers held in one line store RAM.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+---------------------
//   in       | in        | in_valid_i / in_ready_o  | in_data_i  (in_beat_t)
//   out      | out       | out_valid_o / out_ready_i| out_data_o (out_beat_t)
//   cfg      | in        | cfg_we_i, no wait        | cfg_idx_i, cfg_data_i
//
// One beat is accepted per clock unless the window stage stalls on a held
// item; each pushed beat passes the item and line store read registers,
// then the window stage into the output register. The line store port
// pair (one read, one write a cycle) sets the rate; a write and read of
// the same column in consecutive beats is forwarded. A result appears W+1
// beats after its pixel; after the last pixel the host sends W+1 drains.
// Reset clears the position, drain count, window and output register; the
// line store needs no clearing. A stalled output holds the window stage,
// which in turn holds input ready low; the output register decouples the
// two sides so a new beat enters while a finished result waits.
// ----------------------------------------------------------------------------
module outer_contour_marker_3x3 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ocm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ocm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ocm_pkg::in_beat_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ocm_pkg::out_beat_t            out_data_o
);

  ocm_pkg::ocm_item_t            item;
  logic                          take;
  logic                          rd_en, wr_en;
  logic [ocm_pkg::ColW-1:0]      rd_addr, wr_addr;
  logic [ocm_pkg::LineW-1:0]     rd_data, wr_data;

  // Position tracking, drain bookkeeping and the read side of the store.
  ocm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .item_o     (item)
  );

  // Each entry keeps the upper-row and middle-row pixel of one column.
  ocm_ram #(
    .Width (ocm_pkg::LineW),
    .Depth (ocm_pkg::MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Window, contour rule, write-back and output register.
  ocm_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .rd_data_i   (rd_data),
    .take_o      (take),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
